/* rtl/core/rfa_pkg.sv */
// Package for the rational fraction ALU: operation and error codes,
// controller states, command and status structs. No dependencies.
package rfa_pkg;

  localparam int unsigned NumBitsDef = 16;
  localparam int unsigned DenBitsDef = 16;
  localparam int unsigned OpW = 4;
  localparam int unsigned ResNumW = 33;
  localparam int unsigned ResDenW = 32;
  localparam int unsigned ErrW = 2;

  localparam logic [OpW-1:0] OP_ADD = 4'd0;
  localparam logic [OpW-1:0] OP_SUB = 4'd1;
  localparam logic [OpW-1:0] OP_MUL = 4'd2;
  localparam logic [OpW-1:0] OP_DIV = 4'd3;
  localparam logic [OpW-1:0] OP_LT  = 4'd4;
  localparam logic [OpW-1:0] OP_GT  = 4'd5;
  localparam logic [OpW-1:0] OP_LE  = 4'd6;
  localparam logic [OpW-1:0] OP_GE  = 4'd7;
  localparam logic [OpW-1:0] OP_EQ  = 4'd8;
  localparam logic [OpW-1:0] OP_NE  = 4'd9;
  localparam logic [OpW-1:0] OP_INC = 4'd10;

  localparam logic [ErrW-1:0] ERR_NONE = 2'd0;
  localparam logic [ErrW-1:0] ERR_DEN  = 2'd1;
  localparam logic [ErrW-1:0] ERR_DIV0 = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GCD,
    ST_DIVA,
    ST_DIVB,
    ST_MUL,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic gcd_step;
    logic div_start;
    logic div_step;
    logic div_sel_b;
    logic mul_step;
    logic finish;
  } ctrl_t;

  typedef struct packed {
    logic gcd_done;
    logic div_done;
    logic need_lcm;
  } stat_t;

  function automatic logic op_uses_lcm(input logic [OpW-1:0] op);
    logic r;
    r = (op == OP_ADD) || (op == OP_SUB) || (op == OP_LT) || (op == OP_GT) ||
        (op == OP_LE) || (op == OP_GE) || (op == OP_EQ) || (op == OP_NE);
    return r;
  endfunction

endpackage

/* rtl/core/rfa_ctrl.sv */
// Controller for the rational fraction ALU: sequences gcd, the two
// quotient divisions and the final multiply. Uses rfa_pkg.
module rfa_ctrl import rfa_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  stat_t stat_i,
  output ctrl_t ctrl_o,
  output logic  busy_o,
  output logic  done_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) state_d = ST_GCD;
      end
      ST_GCD: begin
        if (!stat_i.need_lcm) state_d = ST_DONE;
        else if (stat_i.gcd_done) state_d = ST_DIVA;
      end
      ST_DIVA: begin
        if (stat_i.div_done) state_d = ST_DIVB;
      end
      ST_DIVB: begin
        if (stat_i.div_done) state_d = ST_MUL;
      end
      ST_MUL:  state_d = ST_DONE;
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    busy_o = (state_q != ST_IDLE);
    done_o = 1'b0;
    case (state_q)
      ST_IDLE: ctrl_o.load = start_i;
      ST_GCD: begin
        ctrl_o.gcd_step  = 1'b1;
        ctrl_o.div_start = stat_i.gcd_done;
      end
      ST_DIVA: begin
        ctrl_o.div_step  = 1'b1;
        ctrl_o.div_start = stat_i.div_done;
        ctrl_o.div_sel_b = stat_i.div_done;
      end
      ST_DIVB: begin
        ctrl_o.div_step  = 1'b1;
        ctrl_o.div_sel_b = 1'b1;
      end
      ST_MUL:  ctrl_o.mul_step = 1'b1;
      ST_DONE: begin
        ctrl_o.finish = 1'b1;
        done_o = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

/* rtl/core/rfa_dp.sv */
// Datapath for the rational fraction ALU: operand registers, binary gcd,
// shared restoring divider, multipliers and result formatting. Uses rfa_pkg.
module rfa_dp import rfa_pkg::*; #(
  parameter int unsigned NumBits = NumBitsDef,
  parameter int unsigned DenBits = DenBitsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ctrl_t                     ctrl_i,
  output stat_t                     stat_o,
  input  logic [OpW-1:0]            op_i,
  input  logic signed [NumBits-1:0] a_num_i,
  input  logic [DenBits-1:0]        a_den_i,
  input  logic signed [NumBits-1:0] b_num_i,
  input  logic [DenBits-1:0]        b_den_i,
  output logic signed [ResNumW-1:0] res_num_o,
  output logic [ResDenW-1:0]        res_den_o,
  output logic                      cmp_true_o,
  output logic [ErrW-1:0]           error_o
);

  localparam int unsigned CntW = $clog2(DenBits + 1);
  localparam int unsigned ShW  = $clog2(DenBits + 1);
  localparam int unsigned PW   = NumBits + DenBits + 1;
  localparam int unsigned LW   = 2 * DenBits;

  logic [OpW-1:0]            op_q;
  logic signed [NumBits-1:0] an_q, bn_q;
  logic [DenBits-1:0]        ad_q, bd_q;
  logic [DenBits-1:0]        gx_q, gy_q;
  logic [ShW-1:0]            gsh_q;
  logic [DenBits-1:0]        g_full;
  logic [DenBits-1:0]        dq_q, drem_q, dsor_q, qa_q;
  logic [CntW-1:0]           dcnt_q;
  logic signed [PW-1:0]      ta_q, tb_q;
  logic [LW-1:0]             l_q;
  logic                      err_den, err_div0, need;

  assign err_den  = (ad_q == '0) || ((op_q != OP_INC) && (bd_q == '0));
  assign err_div0 = (op_q == OP_DIV) && (bn_q == '0);
  assign need     = op_uses_lcm(op_q) && !err_den;
  assign g_full   = gx_q << gsh_q;

  assign stat_o.need_lcm = need;
  assign stat_o.gcd_done = (gy_q == '0);
  assign stat_o.div_done = (dcnt_q == '0);

  logic [DenBits:0] rem_sh;
  assign rem_sh = {drem_q, dq_q[DenBits-1]};

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      op_q  <= op_i;
      an_q  <= a_num_i;
      bn_q  <= b_num_i;
      ad_q  <= a_den_i;
      bd_q  <= b_den_i;
      gx_q  <= a_den_i;
      gy_q  <= b_den_i;
      gsh_q <= '0;
    end else if (ctrl_i.gcd_step && gy_q != '0) begin
      if (!gx_q[0] && !gy_q[0]) begin
        gx_q  <= gx_q >> 1;
        gy_q  <= gy_q >> 1;
        gsh_q <= gsh_q + ShW'(1);
      end else if (!gx_q[0]) begin
        gx_q <= gx_q >> 1;
      end else if (!gy_q[0]) begin
        gy_q <= gy_q >> 1;
      end else if (gx_q > gy_q) begin
        gx_q <= gy_q;
        gy_q <= (gx_q - gy_q) >> 1;
      end else begin
        gy_q <= (gy_q - gx_q) >> 1;
      end
    end
    if (ctrl_i.div_start) begin
      dq_q   <= ctrl_i.div_sel_b ? bd_q : ad_q;
      dsor_q <= g_full;
      drem_q <= '0;
      dcnt_q <= CntW'(DenBits);
      if (ctrl_i.div_sel_b) qa_q <= dq_q;
    end else if (ctrl_i.div_step && dcnt_q != '0) begin
      dcnt_q <= dcnt_q - CntW'(1);
      if (rem_sh >= {1'b0, dsor_q}) begin
        drem_q <= DenBits'(rem_sh - {1'b0, dsor_q});
        dq_q   <= {dq_q[DenBits-2:0], 1'b1};
      end else begin
        drem_q <= rem_sh[DenBits-1:0];
        dq_q   <= {dq_q[DenBits-2:0], 1'b0};
      end
    end
    if (ctrl_i.mul_step) begin
      ta_q <= $signed({1'b0, dq_q}) * PW'(an_q);
      tb_q <= $signed({1'b0, qa_q}) * PW'(bn_q);
      l_q  <= LW'(qa_q) * LW'(bd_q);
    end
  end

  logic signed [PW:0]             diff, sum;
  logic signed [ResNumW-1:0]      rn_d, rn_q;
  logic [ResDenW-1:0]             rd_d, rd_q;
  logic                           cmp_d, cmp_q;
  logic [ErrW-1:0]                err_d, err_q;
  logic signed [2*NumBits-1:0]    mul_n;
  logic [2*DenBits-1:0]           mul_d;
  logic signed [NumBits:0]        bn_mag;
  logic signed [NumBits+DenBits:0] div_n;

  assign diff   = (PW+1)'(ta_q) - (PW+1)'(tb_q);
  assign sum    = (PW+1)'(ta_q) + (PW+1)'(tb_q);
  assign mul_n  = (2*NumBits)'(an_q) * (2*NumBits)'(bn_q);
  assign mul_d  = (2*DenBits)'(ad_q) * (2*DenBits)'(bd_q);
  assign bn_mag = bn_q[NumBits-1] ? -(NumBits+1)'(bn_q) : (NumBits+1)'(bn_q);
  assign div_n  = bn_q[NumBits-1] ?
                  -((NumBits+DenBits+1)'(an_q) * $signed({1'b0, bd_q})) :
                  ((NumBits+DenBits+1)'(an_q) * $signed({1'b0, bd_q}));

  always_comb begin
    rn_d = '0;
    rd_d = '0;
    cmp_d = 1'b0;
    err_d = ERR_NONE;
    if (op_q > OP_INC) begin
      err_d = ERR_NONE;
    end else if (err_den) begin
      err_d = ERR_DEN;
    end else begin
      case (op_q)
        OP_INC: begin
          rn_d = ResNumW'($signed(an_q)) + ResNumW'($signed({1'b0, ad_q}));
          rd_d = ResDenW'(ad_q);
        end
        OP_MUL: begin
          rn_d = ResNumW'(mul_n);
          rd_d = ResDenW'(mul_d);
        end
        OP_DIV: begin
          if (err_div0) begin
            err_d = ERR_DIV0;
          end else begin
            rn_d = ResNumW'(div_n);
            rd_d = ResDenW'((2*DenBits+2)'(ad_q) * (2*DenBits+2)'(bn_mag));
          end
        end
        OP_ADD: begin
          rn_d = ResNumW'(sum);
          rd_d = ResDenW'(l_q);
        end
        OP_SUB: begin
          rn_d = ResNumW'(diff);
          rd_d = ResDenW'(l_q);
        end
        OP_LT: cmp_d = diff < 0;
        OP_GT: cmp_d = diff > 0;
        OP_LE: cmp_d = diff <= 0;
        OP_GE: cmp_d = diff >= 0;
        OP_EQ: cmp_d = diff == 0;
        OP_NE: cmp_d = diff != 0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rn_q <= '0;
      rd_q <= '0;
      cmp_q <= 1'b0;
      err_q <= ERR_NONE;
    end else if (ctrl_i.finish) begin
      rn_q <= rn_d;
      rd_q <= rd_d;
      cmp_q <= cmp_d;
      err_q <= err_d;
    end
  end

  assign res_num_o  = rn_q;
  assign res_den_o  = rd_q;
  assign cmp_true_o = cmp_q;
  assign error_o    = err_q;

endmodule

/* rtl/core/rational_fraction_alu.sv */
// Rational fraction ALU: one fraction operation per command word; a result
// appears with done_o high for one cycle, in the cycle after the done state,
// and cannot be held off by the receiver. Mul, div, increment and error cases
// go from the gcd state straight to done; add, sub and the compares run the
// binary gcd loop, the one-bit-a-cycle divider used twice for the lcm and the
// final multiply.
// busy is high from the accepting edge until the result word is shown.
// Depends on rfa_pkg, rfa_ctrl and rfa_dp.
module rational_fraction_alu import rfa_pkg::*; #(
  parameter int unsigned NumBits = NumBitsDef,
  parameter int unsigned DenBits = DenBitsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [OpW-1:0]            op_i,
  input  logic signed [NumBits-1:0] a_num_i,
  input  logic [DenBits-1:0]        a_den_i,
  input  logic signed [NumBits-1:0] b_num_i,
  input  logic [DenBits-1:0]        b_den_i,
  output logic                      done_o,
  output logic signed [ResNumW-1:0] res_num_o,
  output logic [ResDenW-1:0]        res_den_o,
  output logic                      cmp_true_o,
  output logic [ErrW-1:0]           error_o
);

  ctrl_t ctrl;
  stat_t stat;
  logic  done_d, done_q;

  rfa_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .stat_i (stat),
    .ctrl_o (ctrl),
    .busy_o (busy),
    .done_o (done_d)
  );

  rfa_dp #(.NumBits(NumBits), .DenBits(DenBits)) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .stat_o    (stat),
    .op_i      (op_i),
    .a_num_i   (a_num_i),
    .a_den_i   (a_den_i),
    .b_num_i   (b_num_i),
    .b_den_i   (b_den_i),
    .res_num_o (res_num_o),
    .res_den_o (res_den_o),
    .cmp_true_o(cmp_true_o),
    .error_o   (error_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= done_d;
    end
  end

  assign done_o = done_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while still busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && error_o != ERR_NONE) |-> (res_num_o == '0 && res_den_o == '0))
    else $error("error result carries data");

endmodule
